@@ hdl/categorical_sampler_table_assert.svh @@
// Assertion macros for the categorical sampler table.
`ifndef CATEGORICAL_SAMPLER_TABLE_ASSERT_SVH
`define CATEGORICAL_SAMPLER_TABLE_ASSERT_SVH

`ifndef SYNTH
`define CST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cst assertion failed");
`define CST_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cst assertion failed");
`else
`define CST_ASSERT(lbl, prop)
`define CST_ASSERT_NORST(lbl, prop)
`endif

`endif

@@ hdl/cst_pkg.sv @@
// Shared constants, codes and control types of the categorical sampler table.
package cst_pkg;

  localparam int IN_BITS     = 4;
  localparam int OUT_BITS    = 4;
  localparam int WEIGHT_BITS = 8;
  localparam int RANDOM_BITS = 16;

  localparam int NROWS  = 1 << IN_BITS;
  localparam int NCOLS  = 1 << OUT_BITS;
  localparam int ADDR_W = IN_BITS + OUT_BITS;
  localparam int NENT   = 1 << ADDR_W;
  localparam int SUM_W  = WEIGHT_BITS + OUT_BITS;
  localparam int PROD_W = SUM_W + RANDOM_BITS;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    RD_WCOL,
    RD_FIRST,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    mul_en;
    logic    step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/categorical_sampler_table.sv @@
// Top level of the categorical sampler table.
// Inverse-CDF sampler over a table of 16 rows by 16 columns of 8-bit weights,
// with a running 12-bit sum per row; all weights read as zero after reset.
// A write word (op 0) stores one weight: it accepts the word, reads the old
// weight from the store, then writes the new one and adjusts the row sum.
// A sample word (op 1) accepts the word, does the fraction-times-sum multiply,
// then reads the store once per column walked (up to 16), then hands the
// column to the output register once that register is free. The column walk
// through the store, one column per cycle, sets the sample time. A new word is
// taken only when the previous one has finished; a pending result in the
// output register does not hold back writes.
module categorical_sampler_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [cst_pkg::IN_BITS-1:0]     row_index_i,
  input  logic [cst_pkg::OUT_BITS-1:0]    column_index_i,
  input  logic [cst_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic [cst_pkg::RANDOM_BITS-1:0] random_fraction_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cst_pkg::OUT_BITS-1:0]    out_column_o
);

  cst_pkg::cmd_t cmd;
  cst_pkg::sts_t sts;

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cst_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op_i),
    .row_index_i       (row_index_i),
    .column_index_i    (column_index_i),
    .weight_i          (weight_i),
    .random_fraction_i (random_fraction_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_column_o      (out_column_o)
  );

endmodule

@@ hdl/cst_ctrl.sv @@
// Sequencer for weight writes and column walks of the sampler.
`include "categorical_sampler_table_assert.svh"

module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cst_pkg::sts_t sts_i,
  output cst_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WR_RD  = 3'd1;
  localparam logic [2:0] ST_WR_UPD = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.rd_sel    = cst_pkg::RD_WCOL;
    cmd_o.wr_en     = 1'b0;
    cmd_o.mul_en    = 1'b0;
    cmd_o.step      = 1'b0;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = (sts_i.in_op == cst_pkg::OP_WRITE) ? ST_WR_RD : ST_MUL;
        end
      end
      ST_WR_RD: begin
        cmd_o.rd_sel = cst_pkg::RD_WCOL;
        state_d      = ST_WR_UPD;
      end
      ST_WR_UPD: begin
        cmd_o.wr_en = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.rd_sel = cst_pkg::RD_FIRST;
        cmd_o.mul_en = 1'b1;
        state_d      = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.rd_sel = cst_pkg::RD_NEXT;
        cmd_o.step   = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `CST_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
  `CST_ASSERT(a_out_load_free, cmd_o.out_load |-> sts_i.out_free)
  `CST_ASSERT(a_last_col_ends_walk, (state_q == ST_WALK && sts_i.last) |=> (state_q == ST_DONE))
  `CST_ASSERT(a_write_is_short, (state_q == ST_WR_RD) |=> (state_q == ST_WR_UPD) ##1 (state_q == ST_IDLE))

endmodule

@@ hdl/cst_dp.sv @@
// Weight store, row sums, threshold multiply, column walk and result register.
`include "categorical_sampler_table_assert.svh"

module cst_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               op_i,
  input  logic [cst_pkg::IN_BITS-1:0]        row_index_i,
  input  logic [cst_pkg::OUT_BITS-1:0]       column_index_i,
  input  logic [cst_pkg::WEIGHT_BITS-1:0]    weight_i,
  input  logic [cst_pkg::RANDOM_BITS-1:0]    random_fraction_i,
  input  cst_pkg::cmd_t                      cmd_i,
  output cst_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cst_pkg::OUT_BITS-1:0]       out_column_o
);

  // captured word
  logic [cst_pkg::IN_BITS-1:0]     row_q;
  logic [cst_pkg::OUT_BITS-1:0]    wcol_q;
  logic [cst_pkg::WEIGHT_BITS-1:0] w_q;
  logic [cst_pkg::RANDOM_BITS-1:0] frac_q;

  logic [cst_pkg::WEIGHT_BITS-1:0] mem_q [cst_pkg::NENT];
  logic [cst_pkg::NENT-1:0]        vld_q;
  logic [cst_pkg::SUM_W-1:0]       total_q [cst_pkg::NROWS];

  logic [cst_pkg::ADDR_W-1:0]      rd_addr;
  logic [cst_pkg::ADDR_W-1:0]      wr_addr;
  logic [cst_pkg::WEIGHT_BITS-1:0] rdata_q;
  logic                            rvld_q;
  logic [cst_pkg::WEIGHT_BITS-1:0] w_rd;

  logic [cst_pkg::SUM_W-1:0]       sum_row;
  logic [cst_pkg::SUM_W-1:0]       sum_eff;
  logic                            uniform_q;
  logic [cst_pkg::PROD_W-1:0]      prod_q;
  logic [cst_pkg::SUM_W-1:0]       cum_q;
  logic [cst_pkg::SUM_W-1:0]       cum_next;
  logic [cst_pkg::SUM_W-1:0]       w_eff;
  logic [cst_pkg::OUT_BITS-1:0]    col_q;
  logic                            hit;
  logic                            last;

  logic                            out_valid_q;
  logic [cst_pkg::OUT_BITS-1:0]    out_col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q  <= row_index_i;
      wcol_q <= column_index_i;
      w_q    <= weight_i;
      frac_q <= random_fraction_i;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      cst_pkg::RD_WCOL:  rd_addr = {row_q, wcol_q};
      cst_pkg::RD_FIRST: rd_addr = {row_q, {cst_pkg::OUT_BITS{1'b0}}};
      cst_pkg::RD_NEXT:  rd_addr = {row_q, col_q + cst_pkg::OUT_BITS'(1)};
      default:           rd_addr = {row_q, wcol_q};
    endcase
  end

  assign wr_addr = {row_q, wcol_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= w_q;
    end
    rdata_q <= mem_q[rd_addr];
    rvld_q  <= vld_q[rd_addr];
  end

  // entries never written read as zero
  assign w_rd = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      total_q <= '{default: '0};
    end else if (cmd_i.wr_en) begin
      vld_q[wr_addr] <= 1'b1;
      total_q[row_q] <= total_q[row_q] - cst_pkg::SUM_W'(w_rd) + cst_pkg::SUM_W'(w_q);
    end
  end

  // an empty row behaves as if every column had weight one
  assign sum_row = total_q[row_q];
  assign sum_eff = (sum_row == '0) ? cst_pkg::SUM_W'(cst_pkg::NCOLS) : sum_row;
  assign w_eff   = uniform_q ? cst_pkg::SUM_W'(1) : cst_pkg::SUM_W'(w_rd);
  assign cum_next = cum_q + w_eff;
  assign hit     = {cum_next, {cst_pkg::RANDOM_BITS{1'b0}}} >= prod_q;
  assign last    = &col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q    <= cst_pkg::PROD_W'(frac_q) * cst_pkg::PROD_W'(sum_eff);
      uniform_q <= (sum_row == '0);
      cum_q     <= '0;
      col_q     <= '0;
    end else if (cmd_i.step && !(hit || last)) begin
      cum_q <= cum_next;
      col_q <= col_q + cst_pkg::OUT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_q <= col_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_column_o   = out_col_q;
  assign sts_o.in_op    = op_i;
  assign sts_o.hit      = hit;
  assign sts_o.last     = last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  `CST_ASSERT(a_out_held, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_column_o)))
  `CST_ASSERT(a_zero_frac_first, (cmd_i.step && col_q == '0 && prod_q == '0) |-> hit)
  `CST_ASSERT(a_write_marks_valid, cmd_i.wr_en |=> vld_q[$past(wr_addr)])

endmodule

@@ tb/categorical_sampler_table_tb.sv @@
// Testbench of the sampler table: directed words, then random traffic against a predictor.
module categorical_sampler_table_tb;
  import cst_pkg::*;

  localparam int NO_RES     = 16; // columns in a row, also the number of writes to fill one
  localparam int N_RANDOM   = 1430;
  localparam int HOLD_CYC   = 400;
  localparam int TAIL_CYC   = 25;
  localparam int FULL_SUM   = NCOLS * ((1 << WEIGHT_BITS) - 1);

  typedef struct packed {
    logic                   op;
    logic [IN_BITS-1:0]     row;
    logic [OUT_BITS-1:0]    col;
    logic [WEIGHT_BITS-1:0] wgt;
    logic [RANDOM_BITS-1:0] frac;
    logic                   fixed;
    logic [OUT_BITS-1:0]    fcol;
  } word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   op_i;
  logic [IN_BITS-1:0]     row_index_i;
  logic [OUT_BITS-1:0]    column_index_i;
  logic [WEIGHT_BITS-1:0] weight_i;
  logic [RANDOM_BITS-1:0] random_fraction_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [OUT_BITS-1:0]    out_column_o;

  // predictor state
  logic [WEIGHT_BITS-1:0] weight_tab [NENT];
  logic [SUM_W-1:0]       row_sum    [NROWS];
  logic [OUT_BITS-1:0]    column_q   [$];

  int errors;
  int n_words;
  int n_writes;
  int n_samples;
  int n_zero_rows;
  int n_full_rows;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  // directed words; fixed rows carry a column read straight off the definition
  word_t dir_tab [23] = '{
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'h0000, 1'b1, 4'd0},
    '{OP_SAMPLE, 4'd15, 4'd0,  8'd0,   16'hFFFF, 1'b1, 4'd15},
    '{OP_SAMPLE, 4'd3,  4'd0,  8'd0,   16'h8000, 1'b1, 4'd7},
    '{OP_SAMPLE, 4'd9,  4'd0,  8'd0,   16'h0001, 1'b1, 4'd0},
    '{OP_WRITE,  4'd0,  4'd15, 8'd255, 16'hFFFF, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'h0000, 1'b1, 4'd0},
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'hFFFF, 1'b1, 4'd15},
    '{OP_WRITE,  4'd0,  4'd0,  8'd1,   16'h0000, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'h0001, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'h0100, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'h0101, 1'b0, 4'd0},
    '{OP_WRITE,  4'd15, 4'd0,  8'd255, 16'h0000, 1'b0, 4'd0},
    '{OP_WRITE,  4'd15, 4'd15, 8'd255, 16'h0000, 1'b0, 4'd0},
    '{OP_WRITE,  4'd15, 4'd7,  8'd128, 16'h0000, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd15, 4'd0,  8'd0,   16'h8000, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd15, 4'd0,  8'd0,   16'hFFFF, 1'b0, 4'd0},
    '{OP_WRITE,  4'd0,  4'd15, 8'd0,   16'h0000, 1'b0, 4'd0},
    '{OP_WRITE,  4'd0,  4'd0,  8'd0,   16'h0000, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd0,  4'd0,  8'd0,   16'h8000, 1'b1, 4'd7},
    '{OP_WRITE,  4'd10, 4'd5,  8'hAA,  16'h5555, 1'b0, 4'd0},
    '{OP_WRITE,  4'd5,  4'd10, 8'h55,  16'hAAAA, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd5,  4'd0,  8'd0,   16'h5555, 1'b0, 4'd0},
    '{OP_SAMPLE, 4'd10, 4'd15, 8'hFF,  16'hAAAA, 1'b0, 4'd0}
  };

  categorical_sampler_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .row_index_i       (row_index_i),
    .column_index_i    (column_index_i),
    .weight_i          (weight_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_column_o      (out_column_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // inverse-CDF draw over the predicted table
  function automatic logic [OUT_BITS-1:0] draw_column(input logic [IN_BITS-1:0] r,
                                                      input logic [RANDOM_BITS-1:0] f);
    logic [63:0] cum;
    logic [63:0] total;
    cum   = 64'd0;
    total = 64'(row_sum[r]);
    for (int c = 0; c < NCOLS; c++) begin
      if (total == 64'd0) begin
        // empty row: every column weighs 2^-OUT_BITS
        if ((64'(c + 1) << RANDOM_BITS) >= (64'(f) << OUT_BITS)) return OUT_BITS'(c);
      end else begin
        cum = cum + 64'(weight_tab[{r, OUT_BITS'(c)}]);
        if ((cum << RANDOM_BITS) >= 64'(f) * total) return OUT_BITS'(c);
      end
    end
    return OUT_BITS'(NCOLS - 1);
  endfunction

  function automatic word_t mk_word(input logic o, input logic [IN_BITS-1:0] r,
                                    input logic [OUT_BITS-1:0] c,
                                    input logic [WEIGHT_BITS-1:0] w,
                                    input logic [RANDOM_BITS-1:0] f);
    word_t x;
    x = '{o, r, c, w, f, 1'b0, '0};
    return x;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] rand_weight();
    int k;
    k = $urandom_range(0, 99);
    if (k < 20) return '0;
    if (k < 40) return '1;
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic logic [RANDOM_BITS-1:0] rand_frac();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return '0;
    if (k < 20) return '1;
    if (k < 30) return RANDOM_BITS'($urandom_range(1, 15));
    return RANDOM_BITS'($urandom);
  endfunction

  // offer one word, then fold it into the predictor at the edge it is taken
  task automatic send_word(input word_t w);
    logic [OUT_BITS-1:0] col;
    while (tx_idle_on && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= w.op;
    row_index_i       <= w.row;
    column_index_i    <= w.col;
    weight_i          <= w.wgt;
    random_fraction_i <= w.frac;
    do @(posedge clk_i); while (!in_ready_o);
    n_words++;
    if (w.op == OP_WRITE) begin
      row_sum[w.row] = row_sum[w.row] - SUM_W'(weight_tab[{w.row, w.col}]) + SUM_W'(w.wgt);
      weight_tab[{w.row, w.col}] = w.wgt;
      n_writes++;
    end else begin
      col = draw_column(w.row, w.frac);
      if (row_sum[w.row] == '0) n_zero_rows++;
      if (int'(row_sum[w.row]) == FULL_SUM) n_full_rows++;
      column_q.push_back(w.fixed ? w.fcol : col);
      n_samples++;
    end
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end else begin
        out_ready_i <= !(rx_idle_on && $urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk_i) begin : result_chk
    logic [OUT_BITS-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (column_q.size() == 0) begin
        $display("%0t: out_column %0d with no result pending", $time, out_column_o);
        errors++;
      end else begin
        want = column_q.pop_front();
        if (want !== out_column_o) begin
          $display("%0t: out_column mismatch, expected %0d, actual %0d",
                   $time, want, out_column_o);
          errors++;
        end
      end
    end
  end

  initial begin
    bit                   held;
    bit                   paused;
    bit                   full;
    int                   k;
    logic [IN_BITS-1:0]   r;
    rst_ni            <= 1'b0;
    in_valid_i        <= 1'b0;
    op_i              <= OP_WRITE;
    row_index_i       <= '0;
    column_index_i    <= '0;
    weight_i          <= '0;
    random_fraction_i <= '0;
    errors      = 0;
    n_words     = 0;
    n_writes    = 0;
    n_samples   = 0;
    n_zero_rows = 0;
    n_full_rows = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_req    = 1'b0;
    held        = 1'b0;
    paused      = 1'b0;
    weight_tab  = '{default: '0};
    row_sum     = '{default: '0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i]);

    while (n_words < $size(dir_tab) + N_RANDOM) begin
      // a quiet stretch with no idling on either side
      tx_idle_on = !(n_words >= 900 && n_words < 1100);
      rx_idle_on = tx_idle_on;
      if (!held && n_words >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && n_words >= 700) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (column_q.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      k = $urandom_range(0, 99);
      r = IN_BITS'($urandom);
      if (k < 25) begin
        // fill a whole row, now and then with the heaviest weights
        full = ($urandom_range(0, 3) == 0);
        for (int c = 0; c < NO_RES; c++)
          send_word(mk_word(OP_WRITE, r, OUT_BITS'(c), full ? '1 : rand_weight(),
                            RANDOM_BITS'($urandom)));
        repeat (4) send_word(mk_word(OP_SAMPLE, r, OUT_BITS'($urandom),
                                     WEIGHT_BITS'($urandom), rand_frac()));
      end else if (k < 35) begin
        // empty a row so that it falls back to the uniform draw
        for (int c = 0; c < NO_RES; c++)
          send_word(mk_word(OP_WRITE, r, OUT_BITS'(c), '0, RANDOM_BITS'($urandom)));
        repeat (3) send_word(mk_word(OP_SAMPLE, r, OUT_BITS'($urandom),
                                     WEIGHT_BITS'($urandom), rand_frac()));
      end else if (k < 65) begin
        send_word(mk_word(OP_WRITE, r, OUT_BITS'($urandom), rand_weight(),
                          RANDOM_BITS'($urandom)));
      end else begin
        send_word(mk_word(OP_SAMPLE, r, OUT_BITS'($urandom), WEIGHT_BITS'($urandom),
                          rand_frac()));
      end
    end

    in_valid_i <= 1'b0;
    while (column_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("Covered %0d words: %0d weight writes and %0d samples.",
             n_words, n_writes, n_samples);
    $display("Samples on empty rows: %0d, on rows at full weight: %0d, errors: %0d.",
             n_zero_rows, n_full_rows, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still pending", $time, column_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cst_pkg.sv
hdl/cst_ctrl.sv
hdl/cst_dp.sv
hdl/categorical_sampler_table.sv
tb/categorical_sampler_table_tb.sv
